FILE: rtl/cbme_pkg.sv
`default_nettype none
package cbme_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int RESULT_LIMIT  = 16;

   localparam int STAMP_W = 32;
   localparam int SIZE_W  = 16;
   localparam int LIMIT_W = 20;
   localparam int COUNT_W = 5;
   localparam int KIND_W  = 2;

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int TOTAL_W = (SIZE_W + CNT_W > LIMIT_W) ? SIZE_W + CNT_W : LIMIT_W;
   localparam int NUM_W   = $clog2(RESULT_LIMIT + 1);

   localparam int REQ_DATA_W = STAMP_W + SIZE_W;
   localparam int RSP_BITS   = STAMP_W + SIZE_W + LIMIT_W + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int ADDR_W = 3;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd512;
   localparam logic [LIMIT_W-1:0] TOTAL_MAX   = 20'hFFFFF;

   typedef enum logic [0:0] {
      OP_INSERT   = 1'b0,
      OP_OPTIMIZE = 1'b1
   } opcode_type;

   typedef enum logic [ADDR_W-3:0] {
      REG_CAPACITY_LIMIT = 1'b0
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_EVICTED  = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   typedef struct packed {
      logic     load_req;
      logic     idx_init;
      logic     idx_one;
      logic     idx_step;
      logic     ins_write;
      logic     min_init;
      logic     min_step;
      logic     remove;
      logic     out_load;
      kind_type out_kind;
      logic     out_last;
   } cbme_cmd_type;

   typedef struct packed {
      logic full;
      logic at_zero;
      logic ins_more;
      logic min_more;
      logic evict_more;
      logic out_free;
   } cbme_stat_type;

   function automatic logic [LIMIT_W-1:0] sat_total(input logic [TOTAL_W-1:0] t);
      logic [TOTAL_W+LIMIT_W-1:0] w;
      w = (TOTAL_W + LIMIT_W)'(t);
      if (w > (TOTAL_W + LIMIT_W)'(TOTAL_MAX)) begin
         return TOTAL_MAX;
      end
      return w[LIMIT_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+COUNT_W-1:0] w;
      w = (CNT_W + COUNT_W)'(c);
      return w[COUNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/cbme_ctrl.sv
`default_nettype none
module cbme_ctrl
   import cbme_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_opcode,
   output logic               req_tready,
   input  wire cbme_stat_type stat,
   output cbme_cmd_type       cmd
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_INS_CHK   = 11'b000_0000_0010,
      S_INS_SCAN  = 11'b000_0000_0100,
      S_INS_WRITE = 11'b000_0000_1000,
      S_INS_DONE  = 11'b000_0001_0000,
      S_INS_FULL  = 11'b000_0010_0000,
      S_OPT_EVAL  = 11'b000_0100_0000,
      S_NONE_OUT  = 11'b000_1000_0000,
      S_MIN_SCAN  = 11'b001_0000_0000,
      S_REMOVE    = 11'b010_0000_0000,
      S_EVICT_OUT = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_kind = KIND_INSERTED;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in = (req_opcode == OP_OPTIMIZE) ? S_OPT_EVAL : S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (stat.full) begin
               state_in = S_INS_FULL;
            end else if (stat.at_zero) begin
               cmd.idx_init = 1'b1;
               state_in = S_INS_WRITE;
            end else begin
               cmd.idx_init = 1'b1;
               cmd.idx_one  = 1'b1;
               state_in = S_INS_SCAN;
            end
         end
         S_INS_SCAN: begin
            if (stat.ins_more) begin
               cmd.idx_step = 1'b1;
            end else begin
               state_in = S_INS_WRITE;
            end
         end
         S_INS_WRITE: begin
            cmd.ins_write = 1'b1;
            state_in = S_INS_DONE;
         end
         S_INS_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_INSERTED;
               cmd.out_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_INS_FULL: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_REJECTED;
               cmd.out_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OPT_EVAL: begin
            if (stat.evict_more) begin
               cmd.min_init = 1'b1;
               state_in = S_MIN_SCAN;
            end else begin
               state_in = S_NONE_OUT;
            end
         end
         S_NONE_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_NONE;
               cmd.out_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MIN_SCAN: begin
            if (stat.min_more) begin
               cmd.min_step = 1'b1;
            end else begin
               state_in = S_REMOVE;
            end
         end
         S_REMOVE: begin
            cmd.remove = 1'b1;
            state_in = S_EVICT_OUT;
         end
         S_EVICT_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_EVICTED;
               cmd.out_last = !stat.evict_more;
               if (stat.evict_more) begin
                  cmd.min_init = 1'b1;
                  state_in = S_MIN_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/cbme_datapath.sv
`default_nettype none
module cbme_datapath
   import cbme_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cbme_cmd_type        cmd,
   output cbme_stat_type            stat,
   input  wire logic [STAMP_W-1:0]  req_stamp,
   input  wire logic [SIZE_W-1:0]   req_size,
   input  wire logic [LIMIT_W-1:0]  limit,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output kind_type                 rsp_kind,
   output logic [STAMP_W-1:0]       rsp_stamp,
   output logic [SIZE_W-1:0]        rsp_size,
   output logic [LIMIT_W-1:0]       rsp_total,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic                     rsp_last
);

   logic [STAMP_W-1:0] stamp_ff [TABLE_ENTRIES];
   logic [STAMP_W-1:0] stamp_in [TABLE_ENTRIES];
   logic [SIZE_W-1:0]  size_ff  [TABLE_ENTRIES];
   logic [SIZE_W-1:0]  size_in  [TABLE_ENTRIES];

   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [STAMP_W-1:0] new_stamp_ff, new_stamp_in;
   logic [SIZE_W-1:0]  new_size_ff, new_size_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;

   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [STAMP_W-1:0] out_stamp_ff, out_stamp_in;
   logic [SIZE_W-1:0]  out_size_ff, out_size_in;
   logic [LIMIT_W-1:0] out_total_ff, out_total_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic               out_last_ff, out_last_in;

   logic [STAMP_W-1:0] stamp_rd;
   logic [SIZE_W-1:0]  size_rd;
   logic               in_range;

   assign stamp_rd = stamp_ff[idx_ff[IDX_W-1:0]];
   assign size_rd  = size_ff[idx_ff[IDX_W-1:0]];
   assign in_range = (idx_ff < fill_ff);

   always_comb begin
      stat.full       = (fill_ff == CNT_W'(TABLE_ENTRIES));
      stat.at_zero    = (fill_ff == '0) || (new_stamp_ff < stamp_ff[0]);
      stat.ins_more   = in_range && (stamp_rd < new_stamp_ff);
      stat.min_more   = in_range;
      stat.evict_more = (num_ff < NUM_W'(RESULT_LIMIT)) && (fill_ff != '0)
                        && (total_ff > TOTAL_W'(limit));
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      stamp_in      = stamp_ff;
      size_in       = size_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      num_in        = num_ff;
      new_stamp_in  = new_stamp_ff;
      new_size_in   = new_size_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_size_in  = best_size_ff;

      if (cmd.load_req) begin
         new_stamp_in = req_stamp;
         new_size_in  = req_size;
         num_in       = '0;
      end
      if (cmd.idx_init) begin
         idx_in = cmd.idx_one ? CNT_W'(1) : '0;
      end
      if (cmd.idx_step) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.ins_write) begin
         for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (CNT_W'(j) == idx_ff) begin
               stamp_in[j] = new_stamp_ff;
               size_in[j]  = new_size_ff;
            end else if (j > 0 && CNT_W'(j) > idx_ff && CNT_W'(j) <= fill_ff) begin
               stamp_in[j] = stamp_ff[(j > 0) ? j - 1 : 0];
               size_in[j]  = size_ff[(j > 0) ? j - 1 : 0];
            end
         end
         fill_in  = fill_ff + CNT_W'(1);
         total_in = total_ff + TOTAL_W'(new_size_ff);
      end
      if (cmd.min_init) begin
         idx_in        = CNT_W'(1);
         best_idx_in   = '0;
         best_stamp_in = stamp_ff[0];
         best_size_in  = size_ff[0];
      end
      if (cmd.min_step) begin
         if (size_rd < best_size_ff) begin
            best_idx_in   = idx_ff[IDX_W-1:0];
            best_stamp_in = stamp_rd;
            best_size_in  = size_rd;
         end
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.remove) begin
         for (int j = 0; j < TABLE_ENTRIES - 1; j++) begin
            if (CNT_W'(j) >= CNT_W'(best_idx_ff) && CNT_W'(j + 1) < fill_ff) begin
               stamp_in[j] = stamp_ff[j + 1];
               size_in[j]  = size_ff[j + 1];
            end
         end
         fill_in  = fill_ff - CNT_W'(1);
         total_in = total_ff - TOTAL_W'(best_size_ff);
         num_in   = num_ff + NUM_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_stamp_in = out_stamp_ff;
      out_size_in  = out_size_ff;
      out_total_in = out_total_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = cmd.out_kind;
         out_last_in  = cmd.out_last;
         out_total_in = sat_total(total_ff);
         out_count_in = count_out(fill_ff);
         if (cmd.out_kind == KIND_EVICTED) begin
            out_stamp_in = best_stamp_ff;
            out_size_in  = best_size_ff;
         end else begin
            out_stamp_in = '0;
            out_size_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff      <= stamp_in;
      size_ff       <= size_in;
      idx_ff        <= idx_in;
      num_ff        <= num_in;
      new_stamp_ff  <= new_stamp_in;
      new_size_ff   <= new_size_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_size_ff  <= best_size_in;
      out_kind_ff   <= out_kind_in;
      out_stamp_ff  <= out_stamp_in;
      out_size_ff   <= out_size_in;
      out_total_ff  <= out_total_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_stamp = out_stamp_ff;
   assign rsp_size  = out_size_ff;
   assign rsp_total = out_total_ff;
   assign rsp_count = out_count_ff;
   assign rsp_last  = out_last_ff;

endmodule
`default_nettype wire

FILE: rtl/capacity_bounded_min_size_evictor.sv
`default_nettype none
// Channel  Direction  Handshake           Payload
// req      in         tvalid/tready       tuser: opcode; tdata: entry_timestamp, entry_size
// rsp      out        tvalid/tready       tuser: kind; tdata: evicted_timestamp, evicted_size,
//                                         total_size, entry_count; tlast: last
// csr      in         APB, pready high    capacity_limit at byte address 0
//
// Steps per item: insert checks for a full table, scans for the slot of the new entry
// (skipped when it goes to slot 0), writes it and emits the result; a full table is
// rejected after the check. Optimize emits kind none when nothing is evicted, else per
// eviction it scans the stored entries for the smallest size, removes it and emits it.
// One item is worked at a time; the next is taken while the last result waits in the
// output register, and a result not taken stalls the block. Reset empties the table at once.
module capacity_bounded_min_size_evictor
   import cbme_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // entry_timestamp, entry_size
   input  wire logic [0:0]            req_tuser,   // opcode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // evicted_timestamp, evicted_size,
                                                   // total_size, entry_count, zero pad
   output logic [KIND_W-1:0]          rsp_tuser,   // kind
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ADDR_W-1:0]     csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   cbme_cmd_type       cmd;
   cbme_stat_type      stat;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               reg_hit;
   kind_type           rsp_kind;
   logic [STAMP_W-1:0] rsp_stamp;
   logic [SIZE_W-1:0]  rsp_size;
   logic [LIMIT_W-1:0] rsp_total;
   logic [COUNT_W-1:0] rsp_count;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[ADDR_W-1:2] == REG_CAPACITY_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_prdata = reg_hit ? 32'(limit_ff) : '0;

   cbme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser[0]),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cbme_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_stamp (req_tdata[STAMP_W-1:0]),
      .req_size  (req_tdata[STAMP_W+SIZE_W-1:STAMP_W]),
      .limit     (limit_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_kind),
      .rsp_stamp (rsp_stamp),
      .rsp_size  (rsp_size),
      .rsp_total (rsp_total),
      .rsp_count (rsp_count),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = RSP_DATA_W'({rsp_count, rsp_total, rsp_size, rsp_stamp});

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import cbme_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 38;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      kind_type           kind;
      logic [STAMP_W-1:0] ts;
      logic [SIZE_W-1:0]  sz;
      logic [LIMIT_W-1:0] total;
      logic [COUNT_W-1:0] count;
      logic               is_last;
   } outcome_type;

   typedef struct {
      opcode_type         op;
      logic [STAMP_W-1:0] ts;
      logic [SIZE_W-1:0]  sz;
      logic               has_typed;
      kind_type           kind;
      logic [LIMIT_W-1:0] total;
      logic [COUNT_W-1:0] count;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // entry_timestamp, entry_size
   logic [0:0]            req_tuser = 1'b0;  // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // evicted_timestamp, evicted_size,
                                             // total_size, entry_count, zero pad
   logic [KIND_W-1:0]     rsp_tuser;         // kind
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   capacity_bounded_min_size_evictor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [STAMP_W-1:0] stamp_tab [TABLE_ENTRIES];
   logic [SIZE_W-1:0]  size_tab [TABLE_ENTRIES];
   int                 fill_n = 0;
   int                 total_sum = 0;
   logic [LIMIT_W-1:0] limit_val = LIMIT_RESET;

   outcome_type  fresh_outcomes [$];
   outcome_type  pending_outcomes [$];
   stim_row_type directed_rows [$];
   logic         typed_on = 1'b0;
   outcome_type  typed_res = '0;
   logic         hold_off_req = 1'b0;
   logic         send_burst = 1'b0;
   logic         recv_burst = 1'b0;
   int           errors = 0;
   int           cycle_n = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n == CYCLE_LIMIT) begin
         $display("capacity_bounded_min_size_evictor verification failed");
         $finish;
      end
   end

   function automatic void push_outcome(kind_type k, logic [STAMP_W-1:0] t,
                                        logic [SIZE_W-1:0] s, logic l);
      fresh_outcomes.push_back('{k, t, s, LIMIT_W'(total_sum), COUNT_W'(fill_n), l});
   endfunction

   task automatic predict_outcomes(input opcode_type op, input logic [STAMP_W-1:0] ts,
                                   input logic [SIZE_W-1:0] sz);
      int pos;
      int best;
      int n;
      logic [STAMP_W-1:0] out_ts;
      logic [SIZE_W-1:0]  out_sz;
      if (op == OP_INSERT) begin
         if (fill_n >= TABLE_ENTRIES) begin
            push_outcome(KIND_REJECTED, '0, '0, 1'b1);
         end else begin
            if (fill_n == 0 || ts < stamp_tab[0]) begin
               pos = 0;
            end else begin
               pos = 1;
               while (pos < fill_n && stamp_tab[pos] < ts) pos++;
            end
            for (int i = fill_n; i > pos; i--) begin
               stamp_tab[i] = stamp_tab[i-1];
               size_tab[i]  = size_tab[i-1];
            end
            stamp_tab[pos] = ts;
            size_tab[pos]  = sz;
            fill_n++;
            total_sum += sz;
            push_outcome(KIND_INSERTED, '0, '0, 1'b1);
         end
      end else begin
         n = 0;
         while (n < RESULT_LIMIT && fill_n > 0 && total_sum > int'(limit_val)) begin
            best = 0;
            for (int i = 1; i < fill_n; i++) begin
               if (size_tab[i] < size_tab[best]) best = i;
            end
            out_ts = stamp_tab[best];
            out_sz = size_tab[best];
            for (int i = best; i + 1 < fill_n; i++) begin
               stamp_tab[i] = stamp_tab[i+1];
               size_tab[i]  = size_tab[i+1];
            end
            fill_n--;
            stamp_tab[fill_n] = '0;
            size_tab[fill_n]  = '0;
            total_sum -= out_sz;
            push_outcome(KIND_EVICTED, out_ts, out_sz, 1'b0);
            n++;
         end
         if (n == 0) begin
            push_outcome(KIND_NONE, '0, '0, 1'b1);
         end else begin
            fresh_outcomes[fresh_outcomes.size()-1].is_last = 1'b1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      outcome_type got;
      outcome_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = kind_type'(rsp_tuser);
            got.ts      = rsp_tdata[31:0];
            got.sz      = rsp_tdata[47:32];
            got.total   = rsp_tdata[67:48];
            got.count   = rsp_tdata[72:68];
            got.is_last = rsp_tlast;
            if (pending_outcomes.size() == 0) begin
               $display("%0t ns: unexpected item, expected none actual kind %0d",
                        $time, got.kind);
               errors++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("kind", 32'(want.kind), 32'(got.kind));
               check_field("evicted_timestamp", want.ts, got.ts);
               check_field("evicted_size", 32'(want.sz), 32'(got.sz));
               check_field("total_size", 32'(want.total), 32'(got.total));
               check_field("entry_count", 32'(want.count), 32'(got.count));
               check_field("last", 32'(want.is_last), 32'(got.is_last));
            end
         end
         if (req_tvalid && req_tready) begin
            fresh_outcomes.delete();
            predict_outcomes(opcode_type'(req_tuser), req_tdata[31:0], req_tdata[47:32]);
            if (typed_on) begin
               pending_outcomes.push_back(typed_res);
            end else begin
               foreach (fresh_outcomes[k]) pending_outcomes.push_back(fresh_outcomes[k]);
            end
         end
      end
   end

   initial begin : receiver
      int stall;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall = HOLD_CYCLES;
         end else begin
            if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 16);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(input opcode_type op, input logic [STAMP_W-1:0] ts,
                            input logic [SIZE_W-1:0] sz, input logic has_typed,
                            input outcome_type typed);
      int gap;
      if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sz, ts};
      typed_on   <= has_typed;
      typed_res  <= typed;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [LIMIT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {REG_CAPACITY_LIMIT, 2'b00};
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      limit_val = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      stim_row_type       row;
      opcode_type         op;
      logic [STAMP_W-1:0] ts;
      logic [STAMP_W-1:0] prev_ts;
      logic [SIZE_W-1:0]  sz;
      logic [LIMIT_W-1:0] lim;
      foreach (stamp_tab[i]) begin
         stamp_tab[i] = '0;
         size_tab[i]  = '0;
      end
      prev_ts = '0;
      directed_rows.push_back('{OP_OPTIMIZE, 32'd0, 16'd0, 1'b1, KIND_NONE, 20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'd100, 16'd0, 1'b1, KIND_INSERTED, 20'd0, 5'd1});
      directed_rows.push_back('{OP_INSERT, 32'd100, 16'd5, 1'b1, KIND_INSERTED, 20'd5, 5'd2});
      directed_rows.push_back('{OP_INSERT, 32'd0, 16'hFFFF, 1'b1, KIND_INSERTED,
                                20'd65540, 5'd3});
      directed_rows.push_back('{OP_INSERT, 32'hFFFFFFFF, 16'hFFFF, 1'b1, KIND_INSERTED,
                                20'd131075, 5'd4});
      directed_rows.push_back('{OP_INSERT, 32'd100, 16'd7, 1'b1, KIND_INSERTED,
                                20'd131082, 5'd5});
      directed_rows.push_back('{OP_INSERT, 32'd100, 16'd3, 1'b1, KIND_INSERTED,
                                20'd131085, 5'd6});
      directed_rows.push_back('{OP_INSERT, 32'd0, 16'd3, 1'b1, KIND_INSERTED,
                                20'd131088, 5'd7});
      directed_rows.push_back('{OP_INSERT, 32'hAAAAAAAA, 16'h5555, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'h55555555, 16'hAAAA, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'hAAAAAAAA, 16'd3, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'h55555555, 16'd0, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'h7FFFFFFF, 16'h8000, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'h80000000, 16'h7FFF, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'd100, 16'd1, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'd1, 16'hFFFE, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'hFFFFFFFF, 16'd1, 1'b0, KIND_INSERTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'h12345678, 16'h1234, 1'b0, KIND_REJECTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_OPTIMIZE, 32'hFFFFFFFF, 16'hFFFF, 1'b0, KIND_EVICTED,
                                20'd0, 5'd0});
      directed_rows.push_back('{OP_OPTIMIZE, 32'd0, 16'd0, 1'b1, KIND_NONE, 20'd0, 5'd0});
      directed_rows.push_back('{OP_INSERT, 32'd5, 16'd512, 1'b1, KIND_INSERTED, 20'd512, 5'd1});
      directed_rows.push_back('{OP_OPTIMIZE, 32'd0, 16'd0, 1'b1, KIND_NONE, 20'd512, 5'd1});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         send_item(row.op, row.ts, row.sz, row.has_typed,
                   '{row.kind, 32'd0, 16'd0, row.total, row.count, 1'b1});
      end

      for (int p = 0; p < 5; p++) begin
         req_tvalid <= 1'b0;
         drain_results();
         case (p)
            0: lim = '0;
            1: lim = TOTAL_MAX;
            2: lim = 20'd3000;
            3: lim = 20'd150000;
            default: lim = LIMIT_W'($urandom_range(0, 32'hFFFFF));
         endcase
         csr_write(lim);
         if (p == 1) hold_off_req = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            op = ($urandom_range(0, 9) < 7) ? OP_INSERT : OP_OPTIMIZE;
            case ($urandom_range(0, 3))
               0: ts = $urandom;
               1: ts = $urandom_range(0, 15);
               2: ts = prev_ts;
               default: ts = 32'hFFFFFFF0 | $urandom_range(0, 15);
            endcase
            case ($urandom_range(0, 2))
               0: sz = SIZE_W'($urandom_range(0, 16'hFFFF));
               1: sz = SIZE_W'($urandom_range(0, 300));
               default: sz = SIZE_W'($urandom_range(0, 8));
            endcase
            prev_ts = ts;
            send_item(op, ts, sz, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("capacity_bounded_min_size_evictor verification clean");
      end else begin
         $display("capacity_bounded_min_size_evictor verification failed");
      end
      $finish;
   end

endmodule
